// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/ltt_pkg.sv =====
// ----------------------------------------------------------------------------
// Letter trie type lookup package
// Sizes, transaction types, memory entry layout and letter decoding.
// ----------------------------------------------------------------------------
package ltt_pkg;

    localparam int MAX_NODES     = 256;
    localparam int ALPHABET_SIZE = 26;
    localparam int TYPE_BITS     = 8;

    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FREE_W  = $clog2(MAX_NODES + 1);
    localparam int ENTRIES = MAX_NODES * ALPHABET_SIZE;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LET_W   = $clog2(ALPHABET_SIZE);

    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7a;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5a;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef logic [TYPE_BITS-1:0] type_t;
    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [FREE_W-1:0]    free_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [LET_W-1:0]     letter_idx_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic       last_char;
        logic [7:0] type_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] found_type;
        logic [1:0] status;
    } out_item_t;

    // One trie slot: child pointer and the type of a key ending on this letter.
    typedef struct packed {
        node_t child;
        type_t leaf;
    } node_entry_t;

    typedef struct packed {
        logic        wr_en;
        addr_t       wr_addr;
        node_entry_t wr_data;
        logic        rd_en;
        addr_t       rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic        en;
        letter_idx_t idx;
        type_t       data;
    } single_wr_t;

    typedef struct packed {
        logic        ok;
        letter_idx_t idx;
    } letter_t;

    function automatic letter_t letter_of(logic [7:0] c, logic fold);
        letter_t r;
        r.ok  = 1'b0;
        r.idx = '0;
        if (c inside {[CH_LC_A:CH_LC_Z]}) begin
            r.ok  = 1'b1;
            r.idx = LET_W'(c - CH_LC_A);
        end else if (fold && (c inside {[CH_UC_A:CH_UC_Z]})) begin
            r.ok  = 1'b1;
            r.idx = LET_W'(c - CH_UC_A);
        end
        return r;
    endfunction

    function automatic addr_t node_addr(node_t node, letter_idx_t letter);
        return ADDR_W'(node) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(letter);
    endfunction

    function automatic type_t to_type(logic [7:0] v);
        logic [TYPE_BITS+7:0] ext;
        ext = {{TYPE_BITS{1'b0}}, v};
        return ext[TYPE_BITS-1:0];
    endfunction

    function automatic logic [7:0] from_type(type_t t);
        logic [TYPE_BITS+7:0] ext;
        ext = {8'h00, t};
        return ext[7:0];
    endfunction

endpackage

// ===== rtl/ltt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ltt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ltt_single_tbl.sv =====
// ----------------------------------------------------------------------------
// Single-letter type table
// Type codes of one-letter keys, cleared by reset, read combinationally.
// ----------------------------------------------------------------------------
module ltt_single_tbl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ltt_pkg::single_wr_t  wr,
    input  ltt_pkg::letter_idx_t rd_idx,
    output ltt_pkg::type_t       rd_data
);
    import ltt_pkg::*;

    type_t slot_reg [ALPHABET_SIZE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (wr.en) begin
            slot_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = slot_reg[rd_idx];

endmodule

// ===== rtl/ltt_walk.sv =====
// ----------------------------------------------------------------------------
// Trie walk controller
// Per-key walk state, node allocation, memory clearing and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltt_walk (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ltt_pkg::in_item_t      s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ltt_pkg::out_item_t     m_data,
    output ltt_pkg::mem_req_t      mem_req,
    input  ltt_pkg::node_entry_t   mem_rd_data,
    output ltt_pkg::single_wr_t    single_wr,
    output ltt_pkg::letter_idx_t   single_rd_idx,
    input  ltt_pkg::type_t         single_rd_data
);
    import ltt_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_t;

    state_t    state_reg, state_next;
    addr_t     clr_addr_reg, clr_addr_next;
    node_t     cur_node_reg, cur_node_next;
    free_t     next_free_reg, next_free_next;
    logic      at_first_reg, at_first_next;
    logic      key_failed_reg, key_failed_next;
    logic      fail_kind_reg, fail_kind_next;
    logic      key_absent_reg, key_absent_next;
    in_item_t  item_reg, item_next;
    addr_t     addr_reg, addr_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    letter_t   let_in;
    type_t     tval_in;
    type_t     tval_item;
    logic      out_free;
    logic      accept;
    logic      res_valid;
    out_item_t res;
    addr_t     rd_addr;

    assign let_in        = letter_of(s_data.char_code, !s_data.req_type);
    assign tval_in       = to_type(s_data.type_code);
    assign tval_item     = to_type(item_reg.type_code);
    assign single_rd_idx = let_in.idx;
    assign rd_addr       = node_addr(cur_node_reg, let_in.idx);

    // A final character needs the result register, so it waits for it to drain.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && (!s_data.last_char || out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_node_next   = cur_node_reg;
        next_free_next  = next_free_reg;
        at_first_next   = at_first_reg;
        key_failed_next = key_failed_reg;
        fail_kind_next  = fail_kind_reg;
        key_absent_next = key_absent_reg;
        item_next       = item_reg;
        addr_next       = addr_reg;
        mem_req         = '0;
        single_wr       = '0;
        res_valid       = 1'b0;
        res             = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = '0;
                if (clr_addr_reg == ADDR_W'(ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    at_first_next = 1'b0;
                    item_next     = s_data;
                    if (key_failed_reg) begin
                        res_valid  = s_data.last_char;
                        res.status = fail_kind_reg ? STATUS_FULL : STATUS_BAD;
                    end else if (key_absent_reg) begin
                        res_valid  = s_data.last_char;
                        res.status = STATUS_DONE;
                    end else if (!let_in.ok) begin
                        key_failed_next = 1'b1;
                        fail_kind_next  = 1'b0;
                        res_valid       = s_data.last_char;
                        res.status      = STATUS_BAD;
                    end else if (s_data.last_char && at_first_reg) begin
                        single_wr.en   = s_data.req_type;
                        single_wr.idx  = let_in.idx;
                        single_wr.data = tval_in;
                        res_valid      = 1'b1;
                        res.status     = STATUS_DONE;
                        res.found_type = s_data.req_type ? from_type(tval_in)
                                                         : from_type(single_rd_data);
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rd_addr;
                        addr_next       = rd_addr;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // Read data of the slot is valid here; write back before the next read.
                state_next = ST_IDLE;
                if (item_reg.last_char) begin
                    res_valid  = 1'b1;
                    res.status = STATUS_DONE;
                    if (item_reg.req_type) begin
                        mem_req.wr_en        = 1'b1;
                        mem_req.wr_addr      = addr_reg;
                        mem_req.wr_data.child = mem_rd_data.child;
                        mem_req.wr_data.leaf = tval_item;
                        res.found_type       = from_type(tval_item);
                    end else begin
                        res.found_type = from_type(mem_rd_data.leaf);
                    end
                end else if (mem_rd_data.child == '0) begin
                    if (!item_reg.req_type) begin
                        key_absent_next = 1'b1;
                    end else if (next_free_reg == FREE_W'(MAX_NODES)) begin
                        key_failed_next = 1'b1;
                        fail_kind_next  = 1'b1;
                    end else begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = addr_reg;
                        mem_req.wr_data.child = next_free_reg[NODE_W-1:0];
                        mem_req.wr_data.leaf  = mem_rd_data.leaf;
                        cur_node_next         = next_free_reg[NODE_W-1:0];
                        next_free_next        = next_free_reg + 1'b1;
                    end
                end else begin
                    cur_node_next = mem_rd_data.child;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Every result closes its key: back to the root with clean flags.
        if (res_valid) begin
            cur_node_next   = '0;
            at_first_next   = 1'b1;
            key_failed_next = 1'b0;
            fail_kind_next  = 1'b0;
            key_absent_next = 1'b0;
        end

        m_data_next = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            cur_node_reg   <= '0;
            next_free_reg  <= FREE_W'(1);
            at_first_reg   <= 1'b1;
            key_failed_reg <= 1'b0;
            fail_kind_reg  <= 1'b0;
            key_absent_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cur_node_reg   <= cur_node_next;
            next_free_reg  <= next_free_next;
            at_first_reg   <= at_first_next;
            key_failed_reg <= key_failed_next;
            fail_kind_reg  <= fail_kind_next;
            key_absent_reg <= key_absent_next;
            m_valid_reg    <= m_valid_next;
        end
        item_reg   <= item_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

    `ASSERT_IMPLIES(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready)
    `ASSERT_IMPLIES(a_slot_free_for_result, aclk, aresetn, (state_reg == ST_READ) && item_reg.last_char, !m_valid_reg)
    `ASSERT_IMPLIES(a_pool_bound, aclk, aresetn, 1'b1, next_free_reg <= FREE_W'(MAX_NODES))
    `ASSERT_IMPLIES(a_node_allocated, aclk, aresetn, 1'b1, FREE_W'(cur_node_reg) < next_free_reg)
    `ASSERT_NEXT(a_mid_key_not_first, aclk, aresetn, accept && !s_data.last_char, !at_first_reg)

endmodule

// ===== rtl/letter_trie_type_lookup.sv =====
// ----------------------------------------------------------------------------
// Letter trie type lookup
// Keyword to type code map built as a 26-way letter trie in block RAM.
// ----------------------------------------------------------------------------
// Keys arrive one character per transaction, the final one marked by
// last_char, and each final character returns one result. A character that
// walks or updates the trie reads the slot of the current node from the trie
// RAM in ST_IDLE and writes it back, if it changes, in ST_READ, and the next
// character cannot start before the node it reaches is known. One-letter
// keys, characters of a key that already failed or left the trie, and bad
// characters need no RAM access and do not leave ST_IDLE. A final character is
// taken only when the result register is empty or being drained. After reset
// the trie RAM is cleared one slot a cycle while s_ready stays low.
module letter_trie_type_lookup (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ltt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ltt_pkg::out_item_t m_data
);
    import ltt_pkg::*;

    mem_req_t    mem_req;
    node_entry_t mem_rd_data;
    single_wr_t  single_wr;
    letter_idx_t single_rd_idx;
    type_t       single_rd_data;

    ltt_ram #(
        .WIDTH ($bits(node_entry_t)),
        .DEPTH (ENTRIES)
    ) u_trie_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    ltt_single_tbl u_single (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (single_wr),
        .rd_idx  (single_rd_idx),
        .rd_data (single_rd_data)
    );

    ltt_walk u_walk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data),
        .single_wr      (single_wr),
        .single_rd_idx  (single_rd_idx),
        .single_rd_data (single_rd_data)
    );

endmodule

// ===== test/letter_trie_type_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// Letter trie type lookup checker
// Watches both channels, keeps its own copy of the trie, predicts the result
// of every completed key and compares it with what the block returns.
// ----------------------------------------------------------------------------
module letter_trie_type_lookup_checker
    import ltt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        mismatch_count,
    output int        results_owed
);

    node_t trie_child [ENTRIES];
    type_t trie_leaf [ENTRIES];
    type_t one_letter_type [ALPHABET_SIZE];
    int    free_node;
    node_t walk_node;
    bit    first_of_key;
    bit    key_dead;
    bit    dead_from_pool;
    bit    key_missing;

    out_item_t owed_results[$];
    int        errors = 0;
    int        results_seen = 0;

    task automatic clear_key_walk();
        walk_node = '0;
        first_of_key = 1'b1;
        key_dead = 1'b0;
        dead_from_pool = 1'b0;
        key_missing = 1'b0;
    endtask

    // Applies one key character to the trie copy; the final character of a key
    // queues the result that the block owes for it.
    task automatic walk_trie_char(input in_item_t it);
        bit         ins;
        int         letter;
        int         slot;
        node_t      child;
        type_t      found;
        logic [1:0] status;
        out_item_t  res;
        ins = it.req_type;
        found = '0;
        status = STATUS_DONE;
        if (key_dead) begin
            status = dead_from_pool ? STATUS_FULL : STATUS_BAD;
        end else if (!key_missing) begin
            letter = -1;
            if (it.char_code >= CH_LC_A && it.char_code <= CH_LC_Z) begin
                letter = int'(it.char_code - CH_LC_A);
            end else if (!ins && it.char_code >= CH_UC_A && it.char_code <= CH_UC_Z) begin
                letter = int'(it.char_code - CH_UC_A);
            end
            if (letter < 0) begin
                key_dead = 1'b1;
                dead_from_pool = 1'b0;
                status = STATUS_BAD;
            end else if (it.last_char && first_of_key) begin
                if (ins) one_letter_type[letter] = it.type_code;
                found = one_letter_type[letter];
            end else begin
                slot = int'(walk_node) * ALPHABET_SIZE + letter;
                if (it.last_char) begin
                    if (ins) trie_leaf[slot] = it.type_code;
                    found = trie_leaf[slot];
                end else begin
                    child = trie_child[slot];
                    if (child != '0) begin
                        walk_node = child;
                    end else if (!ins) begin
                        key_missing = 1'b1;
                    end else if (free_node >= MAX_NODES) begin
                        key_dead = 1'b1;
                        dead_from_pool = 1'b1;
                    end else begin
                        trie_child[slot] = node_t'(free_node);
                        walk_node = node_t'(free_node);
                        free_node++;
                    end
                end
            end
        end
        first_of_key = 1'b0;
        if (it.last_char) begin
            res.found_type = found;
            res.status = status;
            owed_results.push_back(res);
            clear_key_walk();
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t owed;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                trie_child[i] = '0;
                trie_leaf[i] = '0;
            end
            for (int i = 0; i < ALPHABET_SIZE; i++) one_letter_type[i] = '0;
            free_node = 1;
            clear_key_walk();
            owed_results.delete();
        end else begin
            // A result is always older than a character taken at the same edge.
            if (m_valid && m_ready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%m: result %0d arrived with none owed: found_type %0d status %0d",
                                 results_seen, m_data.found_type, m_data.status);
                end else begin
                    owed = owed_results.pop_front();
                    if (owed.found_type !== m_data.found_type || owed.status !== m_data.status) begin
                        errors++;
                        if (errors <= 10)
                            $display("%m: result %0d: expected found_type %0d status %0d, got found_type %0d status %0d",
                                     results_seen, owed.found_type, owed.status,
                                     m_data.found_type, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) walk_trie_char(s_data);
        end
        results_owed <= owed_results.size();
        mismatch_count <= errors;
    end

endmodule

// ===== test/letter_trie_type_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// Letter trie type lookup testbench
// Sends directed and random keys (inserts, lookups, bad characters, mixed
// requests, pool exhaustion) with bursty traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module letter_trie_type_lookup_tb;
    import ltt_pkg::*;

    localparam int REQ_LOOKUP     = 0;
    localparam int REQ_INSERT     = 1;
    localparam int MODE_MIXED     = 2;
    localparam int RDY_OPEN       = 0;
    localparam int RDY_MOSTLY     = 1;
    localparam int RDY_SELDOM     = 2;
    localparam int RDY_STALLS     = 3;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int MAX_KEY        = 8;
    localparam int KEY_STORE      = 256;
    localparam int WATCHDOG_LIMIT = 30000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    int        mismatches;
    int        owed;

    logic [7:0] key_buf [MAX_KEY];
    int         key_len;
    logic [7:0] stored_key [KEY_STORE][MAX_KEY];
    int         stored_len [KEY_STORE];
    int         stored_cnt = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         ready_mode = RDY_OPEN;
    int         ready_phase_left = 0;
    int         stall_left = 0;

    always #5 aclk = ~aclk;

    letter_trie_type_lookup uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    letter_trie_type_lookup_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatches),
        .results_owed   (owed)
    );

    // The sender works in bursts; valid drops only between bursts.
    task automatic send_char(input int req, input logic [7:0] ch, input bit last,
                             input logic [7:0] tc);
        int gap;
        in_item_t it;
        it.req_type = req[0];
        it.char_code = ch;
        it.last_char = last;
        it.type_code = tc;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge aclk) s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;
    endtask

    // Sends the key in key_buf; lookup characters are randomly put in upper case.
    task automatic send_key(input int mode, input logic [7:0] tc);
        int req;
        logic [7:0] ch;
        for (int i = 0; i < key_len; i++) begin
            req = (mode == MODE_MIXED) ? int'($urandom_range(0, 1)) : mode;
            ch = key_buf[i];
            if (req == REQ_LOOKUP && ch >= CH_LC_A && ch <= CH_LC_Z && $urandom_range(0, 2) == 0)
                ch = ch - (CH_LC_A - CH_UC_A);
            send_char(req, ch, i == key_len - 1,
                      (req == REQ_INSERT) ? tc : 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic set_key(input string s);
        key_len = s.len();
        for (int i = 0; i < key_len; i++) key_buf[i] = s[i];
    endtask

    task automatic make_word(input int len, input int span);
        key_len = len;
        for (int i = 0; i < len; i++) key_buf[i] = CH_LC_A + 8'($urandom_range(0, span - 1));
    endtask

    task automatic keep_word();
        int k;
        k = (stored_cnt < KEY_STORE) ? stored_cnt : int'($urandom_range(0, KEY_STORE - 1));
        if (stored_cnt < KEY_STORE) stored_cnt++;
        stored_len[k] = key_len;
        for (int i = 0; i < key_len; i++) stored_key[k][i] = key_buf[i];
    endtask

    // Loads an earlier inserted key, now and then cut down to a prefix.
    task automatic recall_word();
        int k;
        k = $urandom_range(0, stored_cnt - 1);
        key_len = stored_len[k];
        for (int i = 0; i < key_len; i++) key_buf[i] = stored_key[k][i];
        if ($urandom_range(0, 3) == 0) key_len = $urandom_range(1, key_len);
    endtask

    always @(negedge aclk) begin
        if (ready_phase_left == 0) begin
            ready_mode = $urandom_range(RDY_OPEN, RDY_STALLS);
            ready_phase_left = $urandom_range(50, 300);
        end
        ready_phase_left--;
        case (ready_mode)
            RDY_OPEN: begin
                m_ready <= 1'b1;
            end
            RDY_MOSTLY: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            RDY_SELDOM: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // The count also covers the trie clearing pass that follows reset.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("letter_trie_type_lookup_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int pick;
        int j;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed keys on a fresh trie.
        set_key("a");   send_key(REQ_LOOKUP, 8'h00);
        set_key("z");   send_key(REQ_INSERT, 8'hff);
        set_key("z");   send_char(REQ_LOOKUP, CH_UC_Z, 1'b1, 8'h00);
        set_key("ab");  send_key(REQ_INSERT, 8'h80);
        send_char(REQ_LOOKUP, CH_UC_A, 1'b0, 8'h11);
        send_char(REQ_LOOKUP, CH_UC_A + 8'd1, 1'b1, 8'h22);
        set_key("qqx"); send_key(REQ_LOOKUP, 8'h00);
        send_char(REQ_INSERT, CH_LC_A, 1'b0, 8'h33);
        send_char(REQ_INSERT, CH_UC_A + 8'd1, 1'b1, 8'h33);
        send_char(REQ_LOOKUP, CH_LC_A, 1'b0, 8'h00);
        send_char(REQ_LOOKUP, CH_UC_Z + 8'd1, 1'b0, 8'h00);
        send_char(REQ_LOOKUP, CH_LC_A + 8'd1, 1'b1, 8'h00);
        send_char(REQ_INSERT, CH_LC_A - 8'd1, 1'b1, 8'h7f);
        send_char(REQ_LOOKUP, CH_UC_A - 8'd1, 1'b1, 8'h00);
        send_char(REQ_LOOKUP, 8'h00, 1'b1, 8'h00);
        send_char(REQ_LOOKUP, 8'hff, 1'b1, 8'hff);
        set_key("zy");  send_key(REQ_INSERT, 8'h00);
        send_char(REQ_INSERT, CH_LC_A, 1'b0, 8'h55);
        send_char(REQ_LOOKUP, CH_LC_A + 8'd1, 1'b1, 8'haa);
        send_char(REQ_INSERT, CH_LC_Z + 8'd1, 1'b1, 8'h01);

        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                make_word($urandom_range(2, MAX_KEY), $urandom_range(0, 1) ? 26 : 4);
                keep_word();
                send_key(REQ_INSERT, 8'($urandom_range(0, 255)));
            end else if (pick < 62 && stored_cnt > 0) begin
                recall_word();
                send_key(REQ_LOOKUP, 8'h00);
            end else if (pick < 70) begin
                make_word(1, 26);
                send_key($urandom_range(REQ_LOOKUP, REQ_INSERT), 8'($urandom_range(0, 255)));
            end else if (pick < 78) begin
                make_word($urandom_range(2, 6), 4);
                send_key(REQ_LOOKUP, 8'h00);
            end else if (pick < 88 || stored_cnt == 0) begin
                // Noise: raw bytes mixed with letters, requests mixed per character.
                make_word($urandom_range(1, 5), 26);
                for (int i = 0; i < key_len; i++)
                    if ($urandom_range(0, 1)) key_buf[i] = 8'($urandom_range(0, 255));
                send_key(MODE_MIXED, 8'($urandom_range(0, 255)));
            end else begin
                // Rewrite a known key, sometimes with one bad character in it.
                recall_word();
                if ($urandom_range(0, 2) == 0) begin
                    j = $urandom_range(0, key_len - 1);
                    key_buf[j] = 8'($urandom_range(0, 255));
                end
                send_key(REQ_INSERT, 8'($urandom_range(0, 255)));
            end
        end

        @(negedge aclk) s_valid <= 1'b0;
        while (owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && owed == 0) begin
            $display("letter_trie_type_lookup_tb: done, clean");
        end else begin
            $display("letter_trie_type_lookup_tb: done, errors");
        end
        $finish;
    end

endmodule
